@@ rtl/core/hcp_pkg.sv @@
`timescale 1ns / 1ps
package hcp_pkg;

	localparam int HCP_MAX_WIDTH  = 1024;
	localparam int HCP_MIN_SIZE   = 7;
	localparam int HCP_MAX_HEIGHT = 4096;
	localparam int DIM_W          = 13;
	localparam int ROW_W          = 12;
	localparam int GRAD_LIMIT     = 180;
	localparam int TENSOR_W       = 28;
	localparam int SCORE_W        = 14;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRAD,
		ST_PROD,
		ST_SUM,
		ST_DET,
		ST_SCORE,
		ST_DEC
	} state_t;

	// two rows per column for each of gray, tensor and score
	typedef struct packed {
		logic [SCORE_W-1:0]  s_old;
		logic [SCORE_W-1:0]  s_new;
		logic [TENSOR_W-1:0] t_old;
		logic [TENSOR_W-1:0] t_new;
		logic [7:0]          g_old;
		logic [7:0]          g_new;
	} line_word_t;

	localparam int LINE_W = $bits(line_word_t);

endpackage

@@ rtl/core/hcp_line_mem.sv @@
`timescale 1ns / 1ps
module hcp_line_mem #(
	parameter int DEPTH = 1024,
	parameter int DW    = 8
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/hcp_engine.sv @@
`timescale 1ns / 1ps
module hcp_engine import hcp_pkg::*; #(
	parameter int MAX_WIDTH = HCP_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [DIM_W-1:0]             width_use,
	input  logic [DIM_W-1:0]             height_use,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	input  logic                         frame_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [$clog2(MAX_WIDTH)-1:0] out_col,
	output logic [ROW_W-1:0]             out_row,
	output logic                         corner,
	output logic signed [SCORE_W-1:0]    score,
	output logic                         mem_rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0] mem_rd_addr,
	input  line_word_t                   mem_rd_data,
	output logic                         mem_wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0] mem_wr_addr,
	output line_word_t                   mem_wr_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	state_t state_q, state_d;

	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [AW-1:0]    c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [7:0]       gray_s1;

	logic [7:0]                gw_q [6];
	logic [TENSOR_W-1:0]       tw_q [6];
	logic signed [SCORE_W-1:0] sw_q [6];

	logic signed [8:0]         gx_s2, gy_s2;
	logic [TENSOR_W-1:0]       tensor_s3;
	logic [6:0]                sxx_s4, syy_s4;
	logic signed [7:0]         sxy_s4;
	logic [12:0]               a_s5, b_s5;
	logic [14:0]               t_s5;
	logic signed [SCORE_W-1:0] score_s6;

	logic                      out_valid_q;
	logic [AW-1:0]             out_col_q;
	logic [ROW_W-1:0]          out_row_q;
	logic                      corner_q;
	logic signed [SCORE_W-1:0] score_q;

	logic            acc;
	logic [AW-1:0]   c_in;
	logic [ROW_W-1:0] r_in;
	logic [DIM_W-1:0] c_next, r_next;
	logic [15:0]     gray_sum;
	logic            has_t, has_s, emit, border, leave_dec;

	logic signed [11:0] g [9];
	logic signed [11:0] gx_raw, gy_raw;
	logic signed [8:0]  gx_c, gy_c;
	logic signed [17:0] pxx, pyy, pxy;
	logic [TENSOR_W-1:0] tn [9];
	logic [12:0]        sxx_sum, syy_sum;
	logic signed [13:0] sxy_sum;
	logic [7:0]         tr;
	logic signed [15:0] pss;
	logic signed [14:0] score_w;
	logic signed [SCORE_W-1:0] sn [9];
	logic signed [SCORE_W-1:0] center;
	logic               peak;

	assign acc      = in_valid && (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE);
	assign c_in     = frame_start ? '0 : col_q;
	assign r_in     = frame_start ? '0 : row_q;
	assign c_next   = DIM_W'(c_in) + DIM_W'(1);
	assign r_next   = DIM_W'(r_in) + DIM_W'(1);
	assign gray_sum = 16'(red) * 16'd77 + 16'(green) * 16'd150 + 16'(blue) * 16'd29;

	assign has_t  = (c_s1 >= AW'(1));
	assign has_s  = (c_s1 >= AW'(2));
	assign emit   = (c_s1 >= AW'(3)) && (r_s1 >= ROW_W'(3));
	assign border = (c_s1 < AW'(6)) || (r_s1 < ROW_W'(6))
		|| ((DIM_W'(c_s1) + DIM_W'(1)) > width_use)
		|| ((DIM_W'(r_s1) + DIM_W'(1)) > height_use);
	assign leave_dec = (state_q == ST_DEC) && !(emit && out_valid_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_GRAD;
			ST_GRAD:  state_d = ST_PROD;
			ST_PROD:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_DET;
			ST_DET:   state_d = ST_SCORE;
			ST_SCORE: state_d = ST_DEC;
			ST_DEC:   if (leave_dec) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (c_next >= width_use) begin
				col_q <= '0;
				row_q <= (r_next >= height_use) ? '0 : r_next[ROW_W-1:0];
			end else begin
				col_q <= c_next[AW-1:0];
				row_q <= r_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1    <= c_in;
			r_s1    <= r_in;
			gray_s1 <= gray_sum[15:8];
		end
	end

	// sobel over the gray neighbourhood
	always_comb begin
		g[0] = $signed({4'b0000, gw_q[0]});
		g[3] = $signed({4'b0000, gw_q[1]});
		g[6] = $signed({4'b0000, gw_q[2]});
		g[1] = $signed({4'b0000, gw_q[3]});
		g[4] = $signed({4'b0000, gw_q[4]});
		g[7] = $signed({4'b0000, gw_q[5]});
		g[2] = $signed({4'b0000, mem_rd_data.g_old});
		g[5] = $signed({4'b0000, mem_rd_data.g_new});
		g[8] = $signed({4'b0000, gray_s1});
		gx_raw = (g[2] - g[0]) + ((g[5] - g[3]) <<< 1) + (g[8] - g[6]);
		gy_raw = (g[0] + (g[1] <<< 1) + g[2]) - (g[6] + (g[7] <<< 1) + g[8]);
		if (gx_raw < -12'(GRAD_LIMIT)) gx_c = -9'(GRAD_LIMIT);
		else if (gx_raw > 12'(GRAD_LIMIT)) gx_c = 9'(GRAD_LIMIT);
		else gx_c = gx_raw[8:0];
		if (gy_raw < -12'(GRAD_LIMIT)) gy_c = -9'(GRAD_LIMIT);
		else if (gy_raw > 12'(GRAD_LIMIT)) gy_c = 9'(GRAD_LIMIT);
		else gy_c = gy_raw[8:0];
	end

	assign pxx = gx_s2 * gx_s2;
	assign pyy = gy_s2 * gy_s2;
	assign pxy = gx_s2 * gy_s2;

	// 3x3 tensor sums
	always_comb begin
		tn[0] = tw_q[0];
		tn[3] = tw_q[1];
		tn[6] = tw_q[2];
		tn[1] = tw_q[3];
		tn[4] = tw_q[4];
		tn[7] = tw_q[5];
		tn[2] = mem_rd_data.t_old;
		tn[5] = mem_rd_data.t_new;
		tn[8] = tensor_s3;
		sxx_sum = '0;
		syy_sum = '0;
		sxy_sum = '0;
		for (int k = 0; k < 9; k++) begin
			sxx_sum = sxx_sum + 13'(tn[k][8:0]);
			syy_sum = syy_sum + 13'(tn[k][17:9]);
			sxy_sum = sxy_sum + $signed({{4{tn[k][27]}}, tn[k][27:18]});
		end
	end

	assign tr  = 8'(sxx_s4) + 8'(syy_s4);
	assign pss = sxy_s4 * sxy_s4;
	assign score_w = $signed({2'b00, a_s5}) - $signed({2'b00, b_s5})
		- $signed({4'b0000, t_s5[14:4]});

	// non-maximum check on the score neighbourhood
	always_comb begin
		sn[0] = sw_q[0];
		sn[3] = sw_q[1];
		sn[6] = sw_q[2];
		sn[1] = sw_q[3];
		sn[4] = sw_q[4];
		sn[7] = sw_q[5];
		sn[2] = $signed(mem_rd_data.s_old);
		sn[5] = $signed(mem_rd_data.s_new);
		sn[8] = score_s6;
		center = sn[4];
		peak = (center > 14'sd1);
		for (int k = 0; k < 9; k++) begin
			if (k != 4 && center < sn[k]) peak = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GRAD) begin
			gx_s2 <= gx_c;
			gy_s2 <= gy_c;
		end
		if (state_q == ST_PROD) begin
			tensor_s3 <= {pxy[15:6], pyy[14:6], pxx[14:6]};
		end
		if (state_q == ST_SUM) begin
			sxx_s4 <= sxx_sum[12:6];
			syy_s4 <= syy_sum[12:6];
			sxy_s4 <= sxy_sum[13:6];
		end
		if (state_q == ST_DET) begin
			a_s5 <= 13'(sxx_s4 * syy_s4);
			b_s5 <= pss[12:0];
			t_s5 <= 15'(tr * tr);
		end
		if (state_q == ST_SCORE) begin
			score_s6 <= score_w[SCORE_W-1:0];
		end
	end

	// window columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				gw_q[k] <= '0;
				tw_q[k] <= '0;
				sw_q[k] <= '0;
			end
		end else begin
			if (state_q == ST_GRAD) begin
				for (int k = 0; k < 3; k++) gw_q[k] <= gw_q[k+3];
				gw_q[3] <= mem_rd_data.g_old;
				gw_q[4] <= mem_rd_data.g_new;
				gw_q[5] <= gray_s1;
			end
			if (state_q == ST_SUM && has_t) begin
				for (int k = 0; k < 3; k++) tw_q[k] <= tw_q[k+3];
				tw_q[3] <= mem_rd_data.t_old;
				tw_q[4] <= mem_rd_data.t_new;
				tw_q[5] <= tensor_s3;
			end
			if (leave_dec && has_s) begin
				for (int k = 0; k < 3; k++) sw_q[k] <= sw_q[k+3];
				sw_q[3] <= $signed(mem_rd_data.s_old);
				sw_q[4] <= $signed(mem_rd_data.s_new);
				sw_q[5] <= score_s6;
			end
		end
	end

	// line store read at transfer, written back once the pixel is done
	assign mem_rd_en   = acc;
	assign mem_rd_addr = c_in;
	assign mem_wr_en   = leave_dec;
	assign mem_wr_addr = c_s1;

	always_comb begin
		mem_wr_data.g_old = mem_rd_data.g_new;
		mem_wr_data.g_new = gray_s1;
		mem_wr_data.t_old = has_t ? mem_rd_data.t_new : mem_rd_data.t_old;
		mem_wr_data.t_new = has_t ? tensor_s3 : mem_rd_data.t_new;
		mem_wr_data.s_old = has_s ? mem_rd_data.s_new : mem_rd_data.s_old;
		mem_wr_data.s_new = has_s ? score_s6 : mem_rd_data.s_new;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (leave_dec && emit) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_dec && emit) begin
			out_col_q <= c_s1 - AW'(3);
			out_row_q <= r_s1 - ROW_W'(3);
			corner_q  <= border ? 1'b0 : peak;
			score_q   <= border ? '0 : center;
		end
	end

	assign out_valid = out_valid_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign corner    = corner_q;
	assign score     = score_q;

endmodule

@@ rtl/core/harris_corner_pixel_stream_core.sv @@
`timescale 1ns / 1ps
// states per pixel: grad, prod, sum, det, score, then dec loads the output register or waits
// a new pixel is taken only in idle, after the previous one is written back to the line store
// the line store holds two rows of gray, tensor and score per column in one memory
// reset: counters, windows, sequencer and output valid are cleared, sizes go to 64 x 64
// reset: line store contents stay undefined, no clearing pass
module harris_corner_pixel_stream_core import hcp_pkg::*; #(
	parameter int MAX_WIDTH = HCP_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	input  logic                         frame_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [$clog2(MAX_WIDTH)-1:0] out_col,
	output logic [ROW_W-1:0]             out_row,
	output logic                         corner,
	output logic signed [SCORE_W-1:0]    score,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_index,
	input  logic [DIM_W-1:0]             cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [10:0]      image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [DIM_W-1:0] width_use, height_use;

	logic       mem_rd_en, mem_wr_en;
	logic [AW-1:0] mem_rd_addr, mem_wr_addr;
	line_word_t mem_rd_data, mem_wr_data;

	// configuration transfers are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd64;
			image_height_q <= 13'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[10:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// sizes in use, clamped to the supported range
	always_comb begin
		if (image_width_q < 11'(HCP_MIN_SIZE)) width_use = DIM_W'(HCP_MIN_SIZE);
		else if (DIM_W'(image_width_q) > DIM_W'(MAX_WIDTH)) width_use = DIM_W'(MAX_WIDTH);
		else width_use = DIM_W'(image_width_q);
		if (image_height_q < DIM_W'(HCP_MIN_SIZE)) height_use = DIM_W'(HCP_MIN_SIZE);
		else if (image_height_q > DIM_W'(HCP_MAX_HEIGHT)) height_use = DIM_W'(HCP_MAX_HEIGHT);
		else height_use = image_height_q;
	end

	hcp_engine #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.width_use  (width_use),
		.height_use (height_use),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_col    (out_col),
		.out_row    (out_row),
		.corner     (corner),
		.score      (score),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data)
	);

	// one word per column: gray, tensor and score of the two previous rows
	hcp_line_mem #(
		.DEPTH(MAX_WIDTH),
		.DW   (LINE_W)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

endmodule

@@ sim/tb_harris_corner_pixel_stream_core.sv @@
`timescale 1ns / 1ps
module tb_harris_corner_pixel_stream_core;
	import hcp_pkg::*;

	localparam int MAXW      = HCP_MAX_WIDTH;
	localparam int HOLD_LEN  = 400;
	localparam int SETTLE    = 20;
	localparam int RAND_GOAL = 260;
	localparam int QUIET_AT  = 180;
	localparam int HOLD_AT   = 40;

	typedef struct packed {
		logic [9:0]         col;
		logic [11:0]        row;
		logic               corner;
		logic signed [13:0] score;
	} decision_t;

	typedef struct {
		logic [7:0] rd;
		logic [7:0] gn;
		logic [7:0] bl;
		logic       fs;
		bit         typed;
		decision_t  want;
	} pixel_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         red = '0;
	logic [7:0]         green = '0;
	logic [7:0]         blue = '0;
	logic               frame_start = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [9:0]         out_col;
	logic [ROW_W-1:0]   out_row;
	logic               corner;
	logic signed [13:0] score;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [0:0]         cfg_index = CFG_IMAGE_WIDTH;
	logic [DIM_W-1:0]   cfg_data = '0;

	harris_corner_pixel_stream_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_col(out_col), .out_row(out_row), .corner(corner), .score(score),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state: two rows of line stores and one window per stage
	// stage 0 gray, stage 1 packed tensor, stage 2 score
	int unsigned width_reg, height_reg;
	int unsigned next_col, next_row;
	int          line_mem [3][2*MAXW];
	int          win_mem  [3][6];
	int          hood [9];

	decision_t   pending_decisions [$];
	int          fail_count;
	int          decisions_seen;
	int          corners_seen;
	int          pixels_sent;
	int          rand_pixels;
	bit          quiet;
	logic        hold_req = 1'b0;
	bit          hold_done;
	int          hold_cnt;
	int          stall_cnt;

	function automatic int used_width(int unsigned v);
		if (v < HCP_MIN_SIZE) return HCP_MIN_SIZE;
		if (v > MAXW) return MAXW;
		return v;
	endfunction

	function automatic int used_height(int unsigned v);
		if (v < HCP_MIN_SIZE) return HCP_MIN_SIZE;
		if (v > HCP_MAX_HEIGHT) return HCP_MAX_HEIGHT;
		return v;
	endfunction

	function automatic int as_score(int v);
		logic signed [13:0] t;
		t = v[13:0];
		return t;
	endfunction

	// fill hood with the 3x3 neighbourhood ending at col, then shift window and rows
	function automatic void slide_stage(int st, int col, int fresh);
		int k;
		if (col >= MAXW) col = MAXW - 1;
		for (k = 0; k < 3; k++) begin
			hood[k*3]   = win_mem[st][k];
			hood[k*3+1] = win_mem[st][3+k];
		end
		hood[2] = line_mem[st][MAXW+col];
		hood[5] = line_mem[st][col];
		hood[8] = fresh;
		for (k = 0; k < 3; k++) win_mem[st][k] = win_mem[st][3+k];
		win_mem[st][3] = hood[2];
		win_mem[st][4] = hood[5];
		win_mem[st][5] = hood[8];
		line_mem[st][MAXW+col] = line_mem[st][col];
		line_mem[st][col] = fresh;
	endfunction

	function automatic void clear_model();
		width_reg = 64;
		height_reg = 64;
		next_col = 0;
		next_row = 0;
		foreach (line_mem[s, i]) line_mem[s][i] = 0;
		foreach (win_mem[s, i]) win_mem[s][i] = 0;
	endfunction

	// one pixel into the pipeline model, returns 1 when a decision comes out
	function automatic bit harris_decide(logic [7:0] rd, logic [7:0] gn, logic [7:0] bl,
			logic fs, output decision_t d);
		int w, h, c, r, k, gray, gx, gy, xx, yy, xy, tensor, v;
		int sxx, syy, sxy, det, tr, sc, mid;
		bit is_corner;
		w = used_width(width_reg);
		h = used_height(height_reg);
		d = '0;
		c = fs ? 0 : next_col;
		r = fs ? 0 : next_row;
		if (c >= MAXW) c = MAXW - 1;
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
		gray = (77 * rd + 150 * gn + 29 * bl) >> 8;

		// sobel at (c-1, r-1)
		slide_stage(0, c, gray);
		gx = (hood[2] - hood[0]) + 2 * (hood[5] - hood[3]) + (hood[8] - hood[6]);
		gy = (hood[0] + 2 * hood[1] + hood[2]) - (hood[6] + 2 * hood[7] + hood[8]);
		if (gx > GRAD_LIMIT) gx = GRAD_LIMIT;
		if (gx < -GRAD_LIMIT) gx = -GRAD_LIMIT;
		if (gy > GRAD_LIMIT) gy = GRAD_LIMIT;
		if (gy < -GRAD_LIMIT) gy = -GRAD_LIMIT;
		xx = (gx * gx) >>> 6;
		yy = (gy * gy) >>> 6;
		xy = (gx * gy) >>> 6;
		tensor = xx | (yy << 9) | ((xy & 'h3FF) << 18);
		if (c < 1) return 0;

		// windowed tensor sums and response at (c-2, r-2)
		slide_stage(1, c - 1, tensor);
		sxx = 0;
		syy = 0;
		sxy = 0;
		for (k = 0; k < 9; k++) begin
			v = (hood[k] >> 18) & 'h3FF;
			if (v >= 512) v -= 1024;
			sxx += hood[k] & 'h1FF;
			syy += (hood[k] >> 9) & 'h1FF;
			sxy += v;
		end
		sxx = sxx >>> 6;
		syy = syy >>> 6;
		sxy = sxy >>> 6;
		det = sxx * syy - sxy * sxy;
		tr = sxx + syy;
		sc = det - ((tr * tr) >>> 4);
		if (c < 2) return 0;

		// non-maximum check at (c-3, r-3)
		slide_stage(2, c - 2, sc & 'h3FFF);
		if (c < 3 || r < 3) return 0;
		mid = as_score(hood[4]);
		is_corner = 0;
		if (c - 3 < 3 || r - 3 < 3 || c + 1 > w || r + 1 > h) begin
			mid = 0;
		end else if (mid > 1) begin
			is_corner = 1;
			for (k = 0; k < 9; k++)
				if (k != 4 && mid < as_score(hood[k])) is_corner = 0;
		end
		d.col = 10'(c - 3);
		d.row = 12'(r - 3);
		d.corner = is_corner;
		d.score = 14'(mid);
		return 1;
	endfunction

	// output side: random back-pressure, one long hold when asked
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_cnt = HOLD_LEN;
			out_ready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_cnt = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// decision checker against the oldest pending expectation
	always @(posedge clk) begin
		decision_t e;
		if (arst_n && out_valid && out_ready) begin
			decisions_seen++;
			if (corner) corners_seen++;
			if (pending_decisions.size() == 0) begin
				fail_count++;
				$display("%0t: decision with none pending: col %0d row %0d corner %0d score %0d",
					$time, out_col, out_row, corner, score);
			end else begin
				e = pending_decisions.pop_front();
				if (out_col !== e.col) begin
					fail_count++;
					$display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
				end
				if (out_row !== e.row) begin
					fail_count++;
					$display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
				end
				if (corner !== e.corner) begin
					fail_count++;
					$display("%0t: corner at (%0d,%0d) expected %0d actual %0d",
						$time, e.col, e.row, e.corner, corner);
				end
				if (score !== e.score) begin
					fail_count++;
					$display("%0t: score at (%0d,%0d) expected %0d actual %0d",
						$time, e.col, e.row, e.score, score);
				end
			end
		end
	end

	// one pixel transfer, leaves in_valid high on return
	task automatic send_pixel(logic [7:0] rd, logic [7:0] gn, logic [7:0] bl, logic fs,
			bit typed, decision_t want);
		decision_t d;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= rd;
		green <= gn;
		blue <= bl;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		if (harris_decide(rd, gn, bl, fs, d))
			pending_decisions.push_back(typed ? want : d);
	endtask

	// drain the pipeline; decisions can still be in flight behind the last expected one
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [DIM_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH) width_reg = v & 'h7FF;
		else height_reg = v & 'h1FFF;
	endtask

	// one frame of blocky content (corners) or plain noise; cut > 0 stops early
	task automatic send_frame(int noisy, int cut);
		int fw, fh, bs, n, x, y;
		logic [7:0] lv;
		decision_t none;
		none = '0;
		fw = used_width(width_reg);
		fh = used_height(height_reg);
		bs = $urandom_range(1, 3);
		n = 0;
		for (y = 0; y < fh; y++)
			for (x = 0; x < fw; x++) begin
				if (cut > 0 && n >= cut) return;
				if (noisy) begin
					send_pixel(8'($urandom), 8'($urandom), 8'($urandom), n == 0, 0, none);
				end else begin
					if ((((x >> bs) ^ (y >> bs)) & 1) ^ ($urandom_range(0, 15) == 0))
						lv = 8'(8'd220 + $urandom_range(0, 35));
					else
						lv = 8'($urandom_range(0, 30));
					send_pixel(lv, lv, lv, n == 0, 0, none);
				end
				n++;
			end
	endtask

	// first 25 pixels of a 7 x 7 frame: colour extremes, only the top-left
	// border decision comes out and it must read zero
	pixel_row_t opening [25] = '{
		'{8'hFF, 8'hFF, 8'hFF, 1'b1, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'hFF, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'h00, 8'hFF, 8'h00, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'hFF, 1'b0, 0, '0},
		'{8'hAA, 8'h55, 8'hAA, 1'b0, 0, '0},
		'{8'h55, 8'hAA, 8'h55, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0},
		'{8'h80, 8'h7F, 8'h01, 1'b0, 0, '0},
		'{8'h01, 8'h80, 8'h7F, 1'b0, 0, '0},
		'{8'hFE, 8'hFE, 8'hFE, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0},
		'{8'h0F, 8'hF0, 8'h3C, 1'b0, 0, '0},
		'{8'hC3, 8'h0F, 8'hF0, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 0, '0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1, '{10'd0, 12'd0, 1'b0, 14'sd0}}
	};

	initial begin
		int f, nf;
		clear_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes of 64 x 64, first rows of a frame
		send_frame(0, 200);

		write_reg(CFG_IMAGE_WIDTH, 13'd7);
		write_reg(CFG_IMAGE_HEIGHT, 13'd7);
		foreach (opening[i])
			send_pixel(opening[i].rd, opening[i].gn, opening[i].bl, opening[i].fs,
				opening[i].typed, opening[i].want);

		// below the minimum: both clamp to 7; frames run back to back and wrap
		write_reg(CFG_IMAGE_WIDTH, 13'd0);
		write_reg(CFG_IMAGE_HEIGHT, 13'd0);
		send_frame(0, 0);
		send_frame(1, 0);

		write_reg(CFG_IMAGE_WIDTH, 13'd12);
		write_reg(CFG_IMAGE_HEIGHT, 13'd9);
		send_frame(0, 0);

		// start of the widest line, every data bit set; the register keeps 11 bits
		write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
		write_reg(CFG_IMAGE_HEIGHT, 13'd7);
		send_frame(0, 40);

		// start of the tallest frame on the narrowest line
		write_reg(CFG_IMAGE_WIDTH, 13'd7);
		write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
		send_frame(0, 70);

		// random sizes and content, some frames cut short by an early frame start
		rand_pixels = pixels_sent;
		while (pixels_sent - rand_pixels < RAND_GOAL) begin
			if (pixels_sent - rand_pixels > HOLD_AT) hold_req <= 1'b1;
			quiet = (pixels_sent - rand_pixels) > QUIET_AT;
			write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(7, 12)));
			write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(7, 10)));
			nf = $urandom_range(1, 2);
			for (f = 0; f < nf; f++)
				send_frame($urandom_range(0, 4) == 0,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : 0);
		end

		settle();
		$display("pixels sent %0d, decisions checked %0d, corners among them %0d",
			pixels_sent, decisions_seen, corners_seen);
		$display("full frames from 7 x 7 up to 12 x 10, partial ones up to 1024 wide and 4096 tall");
		if (fail_count == 0)
			$display("tb_harris_corner_pixel_stream_core: clean");
		else
			$display("tb_harris_corner_pixel_stream_core: errors");
		$finish;
	end

	// watchdog
	initial begin
		#(64'd2_000_000);
		$display("tb_harris_corner_pixel_stream_core: errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/hcp_pkg.sv
rtl/core/hcp_line_mem.sv
rtl/core/hcp_engine.sv
rtl/core/harris_corner_pixel_stream_core.sv
sim/tb_harris_corner_pixel_stream_core.sv
